>>> design/tpsf_pkg.sv
// ----------------------------------------------------------------------------
// tpsf_pkg
// Shared constants, widths and codes of the touch panel sample filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tpsf_pkg;

	// scan geometry
	localparam int SAMPLES_PER_GROUP = 5;
	localparam int NUM_GROUPS        = 4;
	localparam int POS_W             = $clog2(SAMPLES_PER_GROUP);
	localparam int GRP_W             = $clog2(NUM_GROUPS);

	// field widths
	localparam int SAMPLE_W = 12;
	localparam int COORD_W  = 16;
	localparam int REPORT_W = 2;
	localparam int SCALE_W  = 18;
	localparam int OFFSET_W = 16;

	// running sum and trimmed sum widths
	localparam int TRIM_DIV = SAMPLES_PER_GROUP - 2;
	localparam int SUM_W    = $clog2(SAMPLES_PER_GROUP * ((1 << SAMPLE_W) - 1) + 1);
	localparam int TRIM_W   = $clog2(TRIM_DIV * ((1 << SAMPLE_W) - 1) + 1);

	// divide by TRIM_DIV through a rounded-up reciprocal, exact over the trimmed range
	localparam int RECIP_SH = TRIM_W + $clog2(TRIM_DIV) + 1;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'(TRIM_DIV) - 64'd1) / 64'(TRIM_DIV));
	localparam int MPROD_W  = TRIM_W + RECIP_W;

	// calibration product
	localparam int AVG_W   = SAMPLE_W;
	localparam int PROD_W  = SCALE_W + AVG_W + 1;
	localparam int QUOT_W  = PROD_W - 16;
	localparam int CAL_W   = COORD_W + 1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = SCALE_W;

	localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_SCALE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_WINDOW = 3'd5;

	// register reset values
	localparam logic [SCALE_W-1:0]  X_SCALE_RST  = -18'sd11678;
	localparam logic [SCALE_W-1:0]  Y_SCALE_RST  = -18'sd8926;
	localparam logic [OFFSET_W-1:0] X_OFFSET_RST = 16'd340;
	localparam logic [OFFSET_W-1:0] Y_OFFSET_RST = 16'd260;
	localparam logic [SAMPLE_W-1:0] WINDOW_RST   = 12'd50;

	// input mode codes
	localparam logic MODE_PEN_UP = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	// cursor report codes
	localparam logic [REPORT_W-1:0] RPT_NONE    = 2'd0;
	localparam logic [REPORT_W-1:0] RPT_TOUCH   = 2'd1;
	localparam logic [REPORT_W-1:0] RPT_RELEASE = 2'd2;

	localparam logic [COORD_W-1:0] COORD_IDLE = 16'hFFFF;

endpackage

`default_nettype wire

>>> design/tpsf_if.sv
// ----------------------------------------------------------------------------
// tpsf_sample_if / tpsf_result_if
// Valid/ready channels for converter samples and filter results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpsf_sample_if import tpsf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                mode;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output mode, output sample, input ready);
	modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface tpsf_result_if import tpsf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                pen_down;
	logic                press_caught;
	logic [COORD_W-1:0]  pos_x;
	logic [COORD_W-1:0]  pos_y;
	logic [COORD_W-1:0]  start_x;
	logic [COORD_W-1:0]  start_y;
	logic [REPORT_W-1:0] cursor_report;
	logic                pair_matched;

	modport source (output valid, output pen_down, output press_caught, output pos_x,
		output pos_y, output start_x, output start_y, output cursor_report,
		output pair_matched, input ready);
	modport sink   (input valid, input pen_down, input press_caught, input pos_x,
		input pos_y, input start_x, input start_y, input cursor_report,
		input pair_matched, output ready);
endinterface

`default_nettype wire

>>> design/touch_panel_sample_filter_unit.sv
// ----------------------------------------------------------------------------
// touch_panel_sample_filter_unit
// Trimmed-mean filter for resistive touch scans with pair matching,
// calibration and the press/release flag machine.
// ----------------------------------------------------------------------------
// Stages: an accepted pen-up tick or final scan sample goes from the input register
//   through the accumulate, divide, match/multiply and calibrate/flags stages to
//   its result in the output register.
// Throughput: one item per cycle; the whole pipeline stalls only while a
//   result waits in the output register and the sink is not ready.
// Reset: arst_n clears pipeline valids, scan counters, flags, coordinates and
//   loads the calibration registers with their defaults.
`default_nettype none

module touch_panel_sample_filter_unit import tpsf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	tpsf_sample_if.sink                sample_ch,
	tpsf_result_if.source              result_ch,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic                raw_mode_q;
	logic [SCALE_W-1:0]  x_scale_q, y_scale_q;
	logic [OFFSET_W-1:0] x_offset_q, y_offset_q;
	logic [SAMPLE_W-1:0] match_window_q;

	// pipeline control
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1: input register
	logic                mode_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	// accumulator state
	logic [POS_W-1:0]    pos_q;
	logic [GRP_W-1:0]    grp_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] min_q, max_q;

	logic                first_pos, last_pos, tick_s1;
	logic [SUM_W-1:0]    sum_nx;
	logic [SAMPLE_W-1:0] min_nx, max_nx;
	logic [TRIM_W-1:0]   trim_nx;

	// stage 2: trimmed sum
	logic              tick_s2;
	logic [GRP_W-1:0]  grp_s2;
	logic [TRIM_W-1:0] trim_s2;
	logic [MPROD_W-1:0] mprod;

	// stage 3: group mean
	logic                tick_s3;
	logic [GRP_W-1:0]    grp_s3;
	logic [SAMPLE_W-1:0] mean_s3;
	logic [SAMPLE_W-1:0] means_q [3];

	logic                last_grp_s3;
	logic [SAMPLE_W-1:0] dx, dy;
	logic                match_c;
	logic [AVG_W:0]      sx, sy;
	logic [AVG_W-1:0]    ax, ay;
	logic signed [PROD_W-1:0] px_c, py_c;

	// stage 4: averaged coordinates and calibration products
	logic                     tick_s4, matched_s4;
	logic [AVG_W-1:0]         ax_s4, ay_s4;
	logic signed [PROD_W-1:0] px_s4, py_s4;

	logic [COORD_W-1:0] cal_x, cal_y;

	// flag machine and coordinate state
	logic               pen_down_q, caught_q;
	logic [COORD_W-1:0] coord_x_q, coord_y_q, start_x_q, start_y_q;

	logic                pen_nx, caught_nx;
	logic [COORD_W-1:0]  cx_nx, cy_nx, stx_nx, sty_nx;
	logic [REPORT_W-1:0] rpt_nx;
	logic                matched_nx;

	// output register
	logic                out_valid_q;
	logic                out_pen_q, out_caught_q, out_matched_q;
	logic [COORD_W-1:0]  out_x_q, out_y_q, out_sx_q, out_sy_q;
	logic [REPORT_W-1:0] out_rpt_q;

	// truncate toward zero of p / 65536, then offset and clamp at zero
	function automatic logic [COORD_W-1:0] calib(logic signed [PROD_W-1:0] p,
		logic [OFFSET_W-1:0] ofs);
		logic signed [PROD_W-1:0] pa;
		logic signed [QUOT_W-1:0] q;
		logic signed [CAL_W-1:0]  r;
		pa = p + (p[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
		q  = pa[PROD_W-1:16];
		r  = $signed({ofs[OFFSET_W-1], ofs}) + CAL_W'(q);
		return r[CAL_W-1] ? '0 : r[COORD_W-1:0];
	endfunction

	// stall everything while a result waits
	assign adv             = !out_valid_q || result_ch.ready;
	assign sample_ch.ready = adv;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q     <= 1'b0;
			x_scale_q      <= X_SCALE_RST;
			y_scale_q      <= Y_SCALE_RST;
			x_offset_q     <= X_OFFSET_RST;
			y_offset_q     <= Y_OFFSET_RST;
			match_window_q <= WINDOW_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RAW_MODE:     raw_mode_q     <= cfg_data[0];
				REG_X_SCALE:      x_scale_q      <= cfg_data[SCALE_W-1:0];
				REG_Y_SCALE:      y_scale_q      <= cfg_data[SCALE_W-1:0];
				REG_X_OFFSET:     x_offset_q     <= cfg_data[OFFSET_W-1:0];
				REG_Y_OFFSET:     y_offset_q     <= cfg_data[OFFSET_W-1:0];
				REG_MATCH_WINDOW: match_window_q <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// running sum, min and max of the current group
	always_comb begin
		tick_s1   = (mode_s1 == MODE_PEN_UP);
		first_pos = (pos_q == '0);
		last_pos  = (pos_q == POS_W'(SAMPLES_PER_GROUP - 1));
		sum_nx    = first_pos ? SUM_W'(sample_s1) : sum_q + SUM_W'(sample_s1);
		min_nx    = (first_pos || sample_s1 < min_q) ? sample_s1 : min_q;
		max_nx    = (first_pos || sample_s1 > max_q) ? sample_s1 : max_q;
		trim_nx   = TRIM_W'(sum_nx - SUM_W'(min_nx) - SUM_W'(max_nx));
	end

	// divide the trimmed sum by the number of kept samples
	assign mprod = MPROD_W'(trim_s2) * MPROD_W'(RECIP);

	// pair check, averages and calibration products
	always_comb begin
		last_grp_s3 = (grp_s3 == GRP_W'(NUM_GROUPS - 1));
		dx      = (means_q[0] > means_q[2]) ? means_q[0] - means_q[2]
			: means_q[2] - means_q[0];
		dy      = (means_q[1] > mean_s3) ? means_q[1] - mean_s3 : mean_s3 - means_q[1];
		match_c = (dx < match_window_q) && (dy < match_window_q);
		sx      = {1'b0, means_q[0]} + {1'b0, means_q[2]};
		sy      = {1'b0, means_q[1]} + {1'b0, mean_s3};
		ax      = sx[AVG_W:1];
		ay      = sy[AVG_W:1];
		px_c    = PROD_W'($signed(x_scale_q)) * PROD_W'($signed({1'b0, ax}));
		py_c    = PROD_W'($signed(y_scale_q)) * PROD_W'($signed({1'b0, ay}));
	end

	assign cal_x = calib(px_s4, x_offset_q);
	assign cal_y = calib(py_s4, y_offset_q);

	// press/release flag machine
	always_comb begin
		pen_nx     = pen_down_q;
		caught_nx  = caught_q;
		cx_nx      = coord_x_q;
		cy_nx      = coord_y_q;
		stx_nx     = start_x_q;
		sty_nx     = start_y_q;
		rpt_nx     = RPT_NONE;
		matched_nx = 1'b0;
		if (tick_s4) begin
			if (pen_down_q) begin
				pen_nx = 1'b0;
				rpt_nx = RPT_RELEASE;
			end else begin
				stx_nx = '0;
				sty_nx = '0;
				cx_nx  = COORD_IDLE;
				cy_nx  = COORD_IDLE;
			end
		end else begin
			rpt_nx     = RPT_TOUCH;
			matched_nx = matched_s4;
			if (matched_s4) begin
				cx_nx = raw_mode_q ? COORD_W'(ax_s4) : cal_x;
				cy_nx = raw_mode_q ? COORD_W'(ay_s4) : cal_y;
			end
			if (!pen_down_q) begin
				pen_nx    = 1'b1;
				caught_nx = 1'b1;
				stx_nx    = cx_nx;
				sty_nx    = cy_nx;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			grp_q       <= '0;
			pen_down_q  <= 1'b0;
			caught_q    <= 1'b0;
			coord_x_q   <= '0;
			coord_y_q   <= '0;
			start_x_q   <= '0;
			start_y_q   <= '0;
		end else if (adv) begin
			v_s1        <= sample_ch.valid;
			v_s2        <= v_s1 && (tick_s1 || last_pos);
			v_s3        <= v_s2;
			v_s4        <= v_s3 && (tick_s3 || last_grp_s3);
			out_valid_q <= v_s4;
			// scan position
			if (v_s1) begin
				if (tick_s1) begin
					pos_q <= '0;
					grp_q <= '0;
				end else if (last_pos) begin
					pos_q <= '0;
					grp_q <= grp_q + 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			// flag and coordinate state
			if (v_s4) begin
				pen_down_q <= pen_nx;
				caught_q   <= caught_nx;
				coord_x_q  <= cx_nx;
				coord_y_q  <= cy_nx;
				start_x_q  <= stx_nx;
				start_y_q  <= sty_nx;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1   <= sample_ch.mode;
			sample_s1 <= sample_ch.sample;
			if (v_s1 && !tick_s1) begin
				sum_q <= sum_nx;
				min_q <= min_nx;
				max_q <= max_nx;
			end
			tick_s2    <= tick_s1;
			grp_s2     <= grp_q;
			trim_s2    <= trim_nx;
			tick_s3    <= tick_s2;
			grp_s3     <= grp_s2;
			mean_s3    <= SAMPLE_W'(mprod >> RECIP_SH);
			// keep the first three means of the scan
			if (v_s3 && !tick_s3 && !last_grp_s3) begin
				means_q[grp_s3] <= mean_s3;
			end
			tick_s4    <= tick_s3;
			matched_s4 <= match_c;
			ax_s4      <= ax;
			ay_s4      <= ay;
			px_s4      <= px_c;
			py_s4      <= py_c;
			out_pen_q     <= pen_nx;
			out_caught_q  <= caught_nx;
			out_x_q       <= cx_nx;
			out_y_q       <= cy_nx;
			out_sx_q      <= stx_nx;
			out_sy_q      <= sty_nx;
			out_rpt_q     <= rpt_nx;
			out_matched_q <= matched_nx;
		end
	end

	// result channel
	assign result_ch.valid         = out_valid_q;
	assign result_ch.pen_down      = out_pen_q;
	assign result_ch.press_caught  = out_caught_q;
	assign result_ch.pos_x         = out_x_q;
	assign result_ch.pos_y         = out_y_q;
	assign result_ch.start_x       = out_sx_q;
	assign result_ch.start_y       = out_sy_q;
	assign result_ch.cursor_report = out_rpt_q;
	assign result_ch.pair_matched  = out_matched_q;

endmodule

`default_nettype wire

>>> design/tpsf_checker.sv
// ----------------------------------------------------------------------------
// tpsf_checker
// Port-level checks of the touch panel sample filter results.
// ----------------------------------------------------------------------------
`default_nettype none

module tpsf_checker import tpsf_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                valid,
	input wire logic                ready,
	input wire logic                pen_down,
	input wire logic                press_caught,
	input wire logic [COORD_W-1:0]  pos_x,
	input wire logic [COORD_W-1:0]  pos_y,
	input wire logic [COORD_W-1:0]  start_x,
	input wire logic [COORD_W-1:0]  start_y,
	input wire logic [REPORT_W-1:0] cursor_report,
	input wire logic                pair_matched
);

	// press caught seen in an earlier transfer
	logic caught_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caught_seen_q <= 1'b0;
		end else if (valid && ready && press_caught) begin
			caught_seen_q <= 1'b1;
		end
	end

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(pos_x) && $stable(cursor_report))
	else $error("result changed while stalled");

	// sticky press flag never drops
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && caught_seen_q |-> press_caught)
	else $error("press caught flag lost");

	// touch reports always show the pen down, releases never match
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && cursor_report == RPT_TOUCH |-> pen_down && press_caught)
	else $error("touch report without pen down");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid && pair_matched |-> cursor_report == RPT_TOUCH)
	else $error("match flag outside a touch report");

	// idle tick parks the coordinates
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && cursor_report == RPT_NONE |-> !pen_down && pos_x == COORD_IDLE
			&& pos_y == COORD_IDLE && start_x == '0 && start_y == '0)
	else $error("idle report with live coordinates");

endmodule

bind touch_panel_sample_filter_unit tpsf_checker u_tpsf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (result_ch.valid),
	.ready        (result_ch.ready),
	.pen_down     (result_ch.pen_down),
	.press_caught (result_ch.press_caught),
	.pos_x        (result_ch.pos_x),
	.pos_y        (result_ch.pos_y),
	.start_x      (result_ch.start_x),
	.start_y      (result_ch.start_y),
	.cursor_report(result_ch.cursor_report),
	.pair_matched (result_ch.pair_matched)
);

`default_nettype wire

>>> sim/touch_panel_sample_filter_unit_checker.sv
// ----------------------------------------------------------------------------
// tpsf_scan_checker
// Watches the sample, result and register ports of the touch filter, keeps a
// shadow of the scan filter and pen state, and compares every result transfer
// with the oldest predicted report.
// ----------------------------------------------------------------------------
module tpsf_scan_checker import tpsf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	tpsf_sample_if                     sample_ch,
	tpsf_result_if                     result_ch,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic                pen_down;
		logic                press_caught;
		logic [COORD_W-1:0]  pos_x;
		logic [COORD_W-1:0]  pos_y;
		logic [COORD_W-1:0]  start_x;
		logic [COORD_W-1:0]  start_y;
		logic [REPORT_W-1:0] cursor_report;
		logic                pair_matched;
	} touch_report_t;

	// reports still owed by the block, oldest first
	touch_report_t report_q[$];

	// shadow of the calibration registers
	logic                       raw_sel;
	logic signed [SCALE_W-1:0]  gain_x;
	logic signed [SCALE_W-1:0]  gain_y;
	logic signed [OFFSET_W-1:0] offs_x;
	logic signed [OFFSET_W-1:0] offs_y;
	logic [SAMPLE_W-1:0]        window;

	// scan accumulation and pen state
	int unsigned         scan_idx;
	int unsigned         acc_sum;
	logic [SAMPLE_W-1:0] acc_min;
	logic [SAMPLE_W-1:0] acc_max;
	logic [SAMPLE_W-1:0] means [NUM_GROUPS-1];
	logic [COORD_W-1:0]  coord [2];
	logic [COORD_W-1:0]  anchor [2];
	logic                down;
	logic                caught;
	int                  errs = 0;

	// offset + gain*value/65536 truncated toward zero, clipped to the coordinate range
	function automatic logic [COORD_W-1:0] scale_to_screen(input logic [SAMPLE_W-1:0] v,
			input logic signed [SCALE_W-1:0] gain, input logic signed [OFFSET_W-1:0] offs);
		longint prod;
		longint lvl;
		prod = longint'(gain) * longint'(v);
		lvl = longint'(offs) + prod / 65536;
		if (lvl < 0)
			return '0;
		if (lvl > 65535)
			return '1;
		return COORD_W'(lvl);
	endfunction

	function automatic bit pair_agrees(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b);
		logic [SAMPLE_W-1:0] d;
		d = (a > b) ? a - b : b - a;
		return d < window;
	endfunction

	function automatic touch_report_t make_report(input logic [REPORT_W-1:0] rpt, input logic hit);
		return '{down, caught, coord[0], coord[1], anchor[0], anchor[1], rpt, hit};
	endfunction

	function automatic string show(input touch_report_t r);
		return $sformatf("down=%0d caught=%0d x=%0d y=%0d sx=%0d sy=%0d rpt=%0d match=%0d",
			r.pen_down, r.press_caught, r.pos_x, r.pos_y, r.start_x, r.start_y,
			r.cursor_report, r.pair_matched);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		touch_report_t       got;
		touch_report_t       want;
		int unsigned         pos;
		int unsigned         grp;
		int unsigned         mean;
		logic [SAMPLE_W:0]   sum_x;
		logic [SAMPLE_W:0]   sum_y;
		logic [REPORT_W-1:0] rpt;
		logic                hit;
		if (!arst_n) begin
			raw_sel  = 1'b0;
			gain_x   = X_SCALE_RST;
			gain_y   = Y_SCALE_RST;
			offs_x   = X_OFFSET_RST;
			offs_y   = Y_OFFSET_RST;
			window   = WINDOW_RST;
			scan_idx = 0;
			acc_sum  = 0;
			acc_min  = '0;
			acc_max  = '0;
			foreach (means[i])
				means[i] = '0;
			foreach (coord[i]) begin
				coord[i]  = '0;
				anchor[i] = '0;
			end
			down   = 1'b0;
			caught = 1'b0;
			report_q.delete();
			pending <= 0;
		end else begin
			// result transfer against the oldest expectation
			if (result_ch.valid && result_ch.ready) begin
				got = '{result_ch.pen_down, result_ch.press_caught, result_ch.pos_x,
					result_ch.pos_y, result_ch.start_x, result_ch.start_y,
					result_ch.cursor_report, result_ch.pair_matched};
				if (report_q.size() == 0) begin
					errs++;
					if (errs <= MAX_REPORTS)
						$display("%0t: unexpected result: %s", $realtime, show(got));
				end else begin
					want = report_q.pop_front();
					if (got !== want) begin
						errs++;
						if (errs <= MAX_REPORTS) begin
							$display("%0t: result mismatch", $realtime);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(got));
						end
					end
				end
			end

			// sample transfer: advance the scan and predict its report
			if (sample_ch.valid && sample_ch.ready) begin
				if (sample_ch.mode == MODE_PEN_UP) begin
					// pen lifted: drop the partial scan, release or go idle
					scan_idx = 0;
					acc_sum  = 0;
					acc_min  = '0;
					acc_max  = '0;
					if (down) begin
						down = 1'b0;
						rpt  = RPT_RELEASE;
					end else begin
						anchor[0] = '0;
						anchor[1] = '0;
						coord[0]  = COORD_IDLE;
						coord[1]  = COORD_IDLE;
						rpt       = RPT_NONE;
					end
					report_q.push_back(make_report(rpt, 1'b0));
				end else begin
					pos = scan_idx % SAMPLES_PER_GROUP;
					grp = scan_idx / SAMPLES_PER_GROUP;
					if (pos == 0) begin
						acc_sum = sample_ch.sample;
						acc_min = sample_ch.sample;
						acc_max = sample_ch.sample;
					end else begin
						acc_sum += sample_ch.sample;
						if (sample_ch.sample < acc_min)
							acc_min = sample_ch.sample;
						if (sample_ch.sample > acc_max)
							acc_max = sample_ch.sample;
					end
					scan_idx++;
					if (pos == SAMPLES_PER_GROUP - 1) begin
						mean = (acc_sum - acc_min - acc_max) / TRIM_DIV;
						if (grp < NUM_GROUPS - 1) begin
							means[grp] = SAMPLE_W'(mean);
						end else begin
							// last Y group closes the scan
							hit = pair_agrees(means[0], means[2]) &&
								pair_agrees(means[1], SAMPLE_W'(mean));
							if (hit) begin
								sum_x = {1'b0, means[0]} + means[2];
								sum_y = {1'b0, means[1]} + SAMPLE_W'(mean);
								if (raw_sel) begin
									coord[0] = COORD_W'(sum_x[SAMPLE_W:1]);
									coord[1] = COORD_W'(sum_y[SAMPLE_W:1]);
								end else begin
									coord[0] = scale_to_screen(sum_x[SAMPLE_W:1], gain_x, offs_x);
									coord[1] = scale_to_screen(sum_y[SAMPLE_W:1], gain_y, offs_y);
								end
							end
							if (!down) begin
								down      = 1'b1;
								caught    = 1'b1;
								anchor[0] = coord[0];
								anchor[1] = coord[1];
							end
							scan_idx = 0;
							acc_sum  = 0;
							acc_min  = '0;
							acc_max  = '0;
							report_q.push_back(make_report(RPT_TOUCH, hit));
						end
					end
				end
			end

			// register writes
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_RAW_MODE:     raw_sel = cfg_data[0];
					REG_X_SCALE:      gain_x  = cfg_data[SCALE_W-1:0];
					REG_Y_SCALE:      gain_y  = cfg_data[SCALE_W-1:0];
					REG_X_OFFSET:     offs_x  = cfg_data[OFFSET_W-1:0];
					REG_Y_OFFSET:     offs_y  = cfg_data[OFFSET_W-1:0];
					REG_MATCH_WINDOW: window  = cfg_data[SAMPLE_W-1:0];
					default: ;
				endcase
			end

			pending    <= report_q.size();
			fail_count <= errs;
		end
	end

endmodule

>>> sim/touch_panel_sample_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// touch_panel_sample_filter_unit_tb
// Feeds pen-down scans, pen-up ticks, broken scans and noise to the touch
// filter under several calibration settings with random gaps and stalls on
// both channels; a separate checker predicts and compares every report.
// ----------------------------------------------------------------------------
module touch_panel_sample_filter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tpsf_pkg::*;

	localparam int SCAN_LEN     = SAMPLES_PER_GROUP * NUM_GROUPS;
	localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
	localparam int PHASE_ITEMS  = 140;
	localparam int NUM_PHASES   = 7;
	localparam int MAX_WAIT     = 8;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

	localparam logic [SCALE_W-1:0]  SCALE_MAX  = 18'h1FFFF;
	localparam logic [SCALE_W-1:0]  SCALE_MIN  = 18'h20000;
	localparam logic [OFFSET_W-1:0] OFFSET_MAX = 16'h7FFF;
	localparam logic [OFFSET_W-1:0] OFFSET_MIN = 16'h8000;

	// one clean scan with the converter extremes as the trimmed outliers
	localparam logic [SAMPLE_W-1:0] DEMO_SCAN [SCAN_LEN] = '{
		0, 1000, 1001, 1002, 4095,
		4095, 2000, 2000, 2001, 0,
		1003, 1003, 1003, 0, 4095,
		2010, 2010, 2010, 4095, 0
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  no_idle = 1'b0;
	logic                  hold_off_req = 1'b0;
	int                    fail_total;
	int                    pending_reports;
	int                    item_count = 0;
	int                    scan_fill = 0;
	int                    cycle_count = 0;

	tpsf_sample_if smp_if();
	tpsf_result_if res_if();

	touch_panel_sample_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (smp_if),
		.result_ch (res_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tpsf_scan_checker u_scan_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_ch  (smp_if),
		.result_ch  (res_if),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_total),
		.pending    (pending_reports)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("touch_panel_sample_filter_unit_tb: FAIL");
		$finish;
	end

	function automatic int clip(input int v);
		return (v < 0) ? 0 : (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
	endfunction

	// one sample-channel transfer after a random gap, called at a falling edge
	task automatic drive_item(input logic md, input logic [SAMPLE_W-1:0] value);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			smp_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		smp_if.valid  = 1'b1;
		smp_if.mode   = md;
		smp_if.sample = value;
		do
			@(posedge clk);
		while (!smp_if.ready);
		@(negedge clk);
		item_count++;
		scan_fill = (md == MODE_PEN_UP) ? 0 : (scan_fill + 1) % SCAN_LEN;
	endtask

	// scan with X/Y centers, pair drift, jitter and rare wild samples
	task automatic drive_scan(input int count);
		int centre [NUM_GROUPS];
		int drift;
		int jit;
		int s;
		if (scan_fill != 0)
			drive_item(MODE_PEN_UP, SAMPLE_W'($urandom));
		centre[0] = $urandom_range(0, SAMPLE_MAX);
		centre[1] = $urandom_range(0, SAMPLE_MAX);
		case ($urandom_range(0, 3))
			0: drift = 0;
			1: drift = 20;
			2: drift = 80;
			default: drift = 600;
		endcase
		centre[2] = clip(centre[0] + int'($urandom_range(0, 2 * drift)) - drift);
		centre[3] = clip(centre[1] + int'($urandom_range(0, 2 * drift)) - drift);
		case ($urandom_range(0, 3))
			0: jit = 0;
			1: jit = 3;
			2: jit = 25;
			default: jit = 300;
		endcase
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 9) == 0)
				s = $urandom_range(0, SAMPLE_MAX);
			else
				s = clip(centre[k / SAMPLES_PER_GROUP] + int'($urandom_range(0, 2 * jit)) - jit);
			drive_item(MODE_SAMPLE, SAMPLE_W'(s));
		end
	endtask

	// wait until every report is in, then let the pipeline empty
	task automatic drain_results();
		while (pending_reports != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// all six registers plus a write to an unmapped index
	task automatic load_calibration(input logic raw, input logic [SCALE_W-1:0] gx,
			input logic [SCALE_W-1:0] gy, input logic [OFFSET_W-1:0] ox,
			input logic [OFFSET_W-1:0] oy, input logic [SAMPLE_W-1:0] win);
		cfg_wr_en = 1'b1;
		cfg_index = REG_RAW_MODE;
		cfg_data  = CFG_DATA_W'(raw);
		@(negedge clk);
		cfg_index = REG_X_SCALE;
		cfg_data  = gx;
		@(negedge clk);
		cfg_index = REG_Y_SCALE;
		cfg_data  = gy;
		@(negedge clk);
		cfg_index = REG_X_OFFSET;
		cfg_data  = CFG_DATA_W'(ox);
		@(negedge clk);
		cfg_index = REG_Y_OFFSET;
		cfg_data  = CFG_DATA_W'(oy);
		@(negedge clk);
		cfg_index = REG_MATCH_WINDOW;
		cfg_data  = CFG_DATA_W'(win);
		@(negedge clk);
		cfg_index = REG_UNUSED;
		cfg_data  = CFG_DATA_W'($urandom);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// result side: random stalls per transfer, long hold-off on request
	initial begin
		int wait_n;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				res_if.ready = 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(negedge clk);
			end
			wait_n = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
			if (wait_n > 0) begin
				res_if.ready = 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			res_if.ready = 1'b1;
			do
				@(posedge clk);
			while (!res_if.valid);
			@(negedge clk);
		end
	end

	// stimulus and verdict
	initial begin
		int target;
		int pick;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_RAW_MODE;
		cfg_data      = '0;
		smp_if.valid  = 1'b0;
		smp_if.mode   = MODE_PEN_UP;
		smp_if.sample = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: idle tick, clean press, release, idle tick
		drive_item(MODE_PEN_UP, '0);
		for (int i = 0; i < SCAN_LEN; i++)
			drive_item(MODE_SAMPLE, DEMO_SCAN[i]);
		drive_item(MODE_PEN_UP, SAMPLE_W'(SAMPLE_MAX));
		drive_item(MODE_PEN_UP, '0);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph != 0) begin
				smp_if.valid = 1'b0;
				drain_results();
			end
			case (ph)
				1: begin
					load_calibration(1'b1, SCALE_W'($urandom), SCALE_W'($urandom),
						OFFSET_W'($urandom), OFFSET_W'($urandom), SAMPLE_W'(SAMPLE_MAX));
					hold_off_req = 1'b1;
				end
				2: begin
					load_calibration(1'b0, SCALE_MAX, SCALE_MAX, OFFSET_MAX, OFFSET_MAX,
						SAMPLE_W'(SAMPLE_MAX));
					no_idle = 1'b1;
				end
				3: begin
					load_calibration(1'b0, SCALE_MIN, SCALE_MIN, OFFSET_MIN, OFFSET_MIN, '0);
					no_idle = 1'b0;
				end
				4: load_calibration(1'b0, SCALE_MIN, SCALE_MAX, OFFSET_MIN, OFFSET_MAX, 12'd200);
				5: load_calibration(1'($urandom_range(0, 1)), SCALE_W'($urandom),
					SCALE_W'($urandom), OFFSET_W'($urandom), OFFSET_W'($urandom),
					SAMPLE_W'($urandom_range(1, 300)));
				6: load_calibration(1'b0, X_SCALE_RST, Y_SCALE_RST, X_OFFSET_RST,
					Y_OFFSET_RST, 12'd1);
				default: ;
			endcase
			target = item_count + PHASE_ITEMS;
			while (item_count < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					drive_scan(SCAN_LEN);
				else if (pick < 85)
					drive_item(MODE_PEN_UP, SAMPLE_W'($urandom));
				else if (pick < 96)
					drive_scan($urandom_range(1, SCAN_LEN - 1));
				else
					drive_item(MODE_SAMPLE, SAMPLE_W'($urandom));
			end
		end

		smp_if.valid = 1'b0;
		drain_results();
		if (fail_total == 0 && pending_reports == 0)
			$display("touch_panel_sample_filter_unit_tb: PASS");
		else
			$display("touch_panel_sample_filter_unit_tb: FAIL");
		$finish;
	end

endmodule
